@@ hdl/acg_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acg_pkg
// Shared types, constants and the arctangent table of the angular gap test.
// ---------------------------------------------------------------------------
package acg_pkg;

   localparam int MAX_NEIGHBORS = 256;
   localparam int ADDR_W        = $clog2(MAX_NEIGHBORS);
   localparam int CNT_W         = ADDR_W + 1;
   localparam int ANGLE_BITS    = 16;
   localparam int GAP_W         = ANGLE_BITS + 1;
   localparam int POS_W         = 20;
   localparam int DIFF_W        = POS_W + 1;
   localparam int PROD_W        = 2 * DIFF_W;
   localparam int RADIUS_W      = 19;
   localparam int CORDIC_STEPS  = 28;
   localparam int STEP_W        = 5;
   localparam int CORDIC_W      = 49;
   localparam int SCALE_SHIFT   = 24;
   localparam int TURN_W        = 32;
   localparam logic [GAP_W-1:0] FULL_TURN = GAP_W'(1) << ANGLE_BITS;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_RADIUS    = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 19'd19200;
   localparam logic [GAP_W-1:0]    THRESHOLD_RESET = 17'd20861;

   typedef struct packed {
      logic signed [POS_W-1:0] center_x;
      logic signed [POS_W-1:0] center_y;
      logic signed [POS_W-1:0] other_x;
      logic signed [POS_W-1:0] other_y;
      logic                    is_self;
      logic                    last_item;
   } req_type;

   typedef struct packed {
      logic             on_boundary;
      logic [GAP_W-1:0] largest_gap;
      logic [CNT_W-1:0] neighbor_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_R, ST_DECIDE, ST_CORDIC, ST_INS_CHK,
      ST_INS_CMP, ST_SCAN_START, ST_SCAN_FIRST, ST_SCAN_STEP, ST_WRAP, ST_RESULT
   } state_type;

   // atan(2^-i) in units of 2^-32 turn, rounded.
   function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [TURN_W-1:0] t;
      case (i)
         5'd0:  t = 32'd536870912;
         5'd1:  t = 32'd316933406;
         5'd2:  t = 32'd167458907;
         5'd3:  t = 32'd85004756;
         5'd4:  t = 32'd42667331;
         5'd5:  t = 32'd21354465;
         5'd6:  t = 32'd10679838;
         5'd7:  t = 32'd5340245;
         5'd8:  t = 32'd2670163;
         5'd9:  t = 32'd1335087;
         5'd10: t = 32'd667544;
         5'd11: t = 32'd333772;
         5'd12: t = 32'd166886;
         5'd13: t = 32'd83443;
         5'd14: t = 32'd41722;
         5'd15: t = 32'd20861;
         5'd16: t = 32'd10430;
         5'd17: t = 32'd5215;
         5'd18: t = 32'd2608;
         5'd19: t = 32'd1304;
         5'd20: t = 32'd652;
         5'd21: t = 32'd326;
         5'd22: t = 32'd163;
         5'd23: t = 32'd81;
         5'd24: t = 32'd41;
         5'd25: t = 32'd20;
         5'd26: t = 32'd10;
         5'd27: t = 32'd5;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

@@ hdl/acg_angle_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acg_angle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module acg_angle_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ hdl/acg_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acg_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle, giving the
// direction angle of a difference vector in fractions of a turn.
// ---------------------------------------------------------------------------
module acg_cordic (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [acg_pkg::DIFF_W-1:0]   dx,
   input  wire logic signed [acg_pkg::DIFF_W-1:0]   dy,
   output      logic                                done,
   output      logic [acg_pkg::ANGLE_BITS-1:0]      angle
);

   localparam int W = acg_pkg::CORDIC_W;

   logic signed [W-1:0]                x_ff, x_in, y_ff, y_in;
   logic [acg_pkg::TURN_W-1:0]         z_ff, z_in;
   logic [acg_pkg::STEP_W-1:0]         step_ff, step_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic signed [W-1:0]                x0, y0, xs, ys;
   logic [acg_pkg::TURN_W-1:0]         z_round;

   // Division by 2^i truncating toward zero.
   function automatic logic signed [W-1:0] trunc_shift(input logic signed [W-1:0] v,
                                                       input logic [acg_pkg::STEP_W-1:0] sh);
      logic signed [W-1:0] r;
      logic [W-1:0]        low_mask;
      low_mask = ~({W{1'b1}} << sh);
      r = v >>> sh;
      if (v[W-1] && ((v & low_mask) != '0)) begin
         r = r + W'(1);
      end
      return r;
   endfunction

   always_comb begin
      x0 = W'(dx) <<< acg_pkg::SCALE_SHIFT;
      y0 = W'(dy) <<< acg_pkg::SCALE_SHIFT;
      xs = trunc_shift(x_ff, step_ff);
      ys = trunc_shift(y_ff, step_ff);
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         if (dx < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = 32'h8000_0000;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + acg_pkg::atan_turn(step_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - acg_pkg::atan_turn(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == acg_pkg::STEP_W'(acg_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   // Round half up; a full turn wraps to zero through the truncation.
   assign z_round = z_ff + (acg_pkg::TURN_W'(1) << (31 - acg_pkg::ANGLE_BITS));
   assign angle   = z_round[acg_pkg::TURN_W-1 -: acg_pkg::ANGLE_BITS];
   assign done    = done_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("cordic restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("cordic done without work");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff < acg_pkg::STEP_W'(acg_pkg::CORDIC_STEPS))
      else $error("cordic step out of range");
`endif

endmodule
`default_nettype wire

@@ hdl/angular_gap_boundary_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// angular_gap_boundary_test
// Boundary test of one centre point from the angular gaps of its neighbours.
// ---------------------------------------------------------------------------
// One item is taken at a time. Each item passes through the distance test in
// a single shared multiplier; a kept neighbour with a nonzero offset then
// goes through the iterative CORDIC, and every kept neighbour is inserted into
// the sorted angle RAM, moving each larger entry up one place. The last item
// of a point further sweeps the RAM once, and its result is held in an output
// register until transferred. Insertion and sweep read the angle RAM through
// its single read port.
module angular_gap_boundary_test (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire acg_pkg::req_type                  req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      acg_pkg::rsp_type                  rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [acg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output      logic [31:0]                       csr_prdata,
   output      logic                              csr_pready
);

   localparam int AW = acg_pkg::ADDR_W;
   localparam int CW = acg_pkg::CNT_W;
   localparam int AB = acg_pkg::ANGLE_BITS;
   localparam int GW = acg_pkg::GAP_W;
   localparam int DW = acg_pkg::DIFF_W;
   localparam int PW = acg_pkg::PROD_W;

   acg_pkg::state_type state_ff, state_in;
   logic [acg_pkg::RADIUS_W-1:0] radius_ff;
   logic [GW-1:0]                threshold_ff;
   logic signed [DW-1:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic                         self_ff, self_in, last_ff, last_in;
   logic signed [DW-1:0]         mul_a;
   logic signed [PW-1:0]         mul_ff, mul_in;
   logic [PW:0]                  acc_ff, acc_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [AB-1:0]                key_ff, key_in;
   logic [AW-1:0]                j_ff, j_in;
   logic [CW-1:0]                i_ff, i_in, i_next;
   logic [AB-1:0]                first_ff, first_in, prev_ff, prev_in;
   logic [GW-1:0]                best_ff, best_in, gap_diff, gap_wrap;
   logic                         rsp_valid_ff, rsp_valid_in;
   acg_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic                         req_accept, csr_write, cordic_start, cordic_done;
   logic [AB-1:0]                cordic_angle;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [AB-1:0]                wr_data, rd_data;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != acg_pkg::ST_IDLE);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= acg_pkg::RADIUS_RESET;
         threshold_ff <= acg_pkg::THRESHOLD_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == acg_pkg::CSR_RADIUS) begin
            radius_ff <= csr_pwdata[acg_pkg::RADIUS_W-1:0];
         end else begin
            threshold_ff <= csr_pwdata[GW-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == acg_pkg::CSR_THRESHOLD) ?
                       32'(threshold_ff) : 32'(radius_ff);

   acg_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   acg_angle_ram #(
      .DEPTH (acg_pkg::MAX_NEIGHBORS),
      .WIDTH (AB)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mul_in   = mul_a * mul_a;
   assign i_next   = i_ff + 1'b1;
   assign gap_diff = GW'(rd_data) - GW'(prev_ff);
   assign gap_wrap = acg_pkg::FULL_TURN - GW'(prev_ff) + GW'(first_ff);

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      self_in      = self_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_a        = dx_ff;
      cordic_start = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = j_ff;
      wr_data      = key_ff;
      rd_addr      = i_ff[AW-1:0];
      case (state_ff)
         acg_pkg::ST_IDLE: begin
            if (req_accept) begin
               dx_in    = DW'(req_data.other_x) - DW'(req_data.center_x);
               dy_in    = DW'(req_data.other_y) - DW'(req_data.center_y);
               self_in  = req_data.is_self;
               last_in  = req_data.last_item;
               state_in = acg_pkg::ST_SQ_X;
            end
         end
         acg_pkg::ST_SQ_X: begin
            mul_a    = dx_ff;
            state_in = acg_pkg::ST_SQ_Y;
         end
         acg_pkg::ST_SQ_Y: begin
            mul_a    = dy_ff;
            acc_in   = (PW+1)'(unsigned'(mul_ff));
            state_in = acg_pkg::ST_SQ_R;
         end
         acg_pkg::ST_SQ_R: begin
            mul_a    = DW'(radius_ff);
            acc_in   = acc_ff + (PW+1)'(unsigned'(mul_ff));
            state_in = acg_pkg::ST_DECIDE;
         end
         acg_pkg::ST_DECIDE: begin
            if (!self_ff && (acc_ff < (PW+1)'(unsigned'(mul_ff))) &&
                (count_ff < CW'(acg_pkg::MAX_NEIGHBORS))) begin
               j_in = count_ff[AW-1:0];
               if (dx_ff == '0 && dy_ff == '0) begin
                  key_in   = '0;
                  state_in = acg_pkg::ST_INS_CHK;
               end else begin
                  cordic_start = 1'b1;
                  state_in     = acg_pkg::ST_CORDIC;
               end
            end else if (last_ff) begin
               state_in = acg_pkg::ST_SCAN_START;
            end else begin
               state_in = acg_pkg::ST_IDLE;
            end
         end
         acg_pkg::ST_CORDIC: begin
            if (cordic_done) begin
               key_in   = cordic_angle;
               state_in = acg_pkg::ST_INS_CHK;
            end
         end
         acg_pkg::ST_INS_CHK: begin
            rd_addr = j_ff - 1'b1;
            if (j_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = last_ff ? acg_pkg::ST_SCAN_START : acg_pkg::ST_IDLE;
            end else begin
               state_in = acg_pkg::ST_INS_CMP;
            end
         end
         acg_pkg::ST_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_data > key_ff) begin
               // Move the larger entry up one place and keep looking down.
               wr_data  = rd_data;
               j_in     = j_ff - 1'b1;
               state_in = acg_pkg::ST_INS_CHK;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = last_ff ? acg_pkg::ST_SCAN_START : acg_pkg::ST_IDLE;
            end
         end
         acg_pkg::ST_SCAN_START: begin
            rd_addr = '0;
            i_in    = CW'(1);
            if (count_ff == '0) begin
               best_in  = acg_pkg::FULL_TURN;
               state_in = acg_pkg::ST_RESULT;
            end else begin
               best_in  = '0;
               state_in = acg_pkg::ST_SCAN_FIRST;
            end
         end
         acg_pkg::ST_SCAN_FIRST: begin
            first_in = rd_data;
            prev_in  = rd_data;
            rd_addr  = i_ff[AW-1:0];
            state_in = (i_ff < count_ff) ? acg_pkg::ST_SCAN_STEP : acg_pkg::ST_WRAP;
         end
         acg_pkg::ST_SCAN_STEP: begin
            prev_in = rd_data;
            if (gap_diff > best_ff) begin
               best_in = gap_diff;
            end
            i_in    = i_next;
            rd_addr = i_next[AW-1:0];
            state_in = (i_next < count_ff) ? acg_pkg::ST_SCAN_STEP : acg_pkg::ST_WRAP;
         end
         acg_pkg::ST_WRAP: begin
            if (gap_wrap > best_ff) begin
               best_in = gap_wrap;
            end
            state_in = acg_pkg::ST_RESULT;
         end
         acg_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.on_boundary    = best_ff > threshold_ff;
               rsp_data_in.largest_gap    = best_ff;
               rsp_data_in.neighbor_count = count_ff;
               count_in                   = '0;
               state_in                   = acg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = acg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acg_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      self_ff     <= self_in;
      last_ff     <= last_in;
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      key_ff      <= key_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      first_ff    <= first_in;
      prev_ff     <= prev_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(acg_pkg::MAX_NEIGHBORS)) else $error("kept count overflow");
   a_write_in_insert: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == acg_pkg::ST_INS_CHK || state_ff == acg_pkg::ST_INS_CMP))
      else $error("angle RAM written outside insertion");
   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == acg_pkg::ST_CORDIC)
      else $error("angle ready outside CORDIC wait");
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acg_pkg::ST_RESULT && (!rsp_valid_ff || !rsp_stall)) |=>
      (count_ff == '0 && rsp_valid_ff)) else $error("store not cleared after result");
`endif

endmodule
`default_nettype wire
